/* hw/rtl/kdeq_pkg.sv */
// ----------------------------------------------------------------------------
// kdeq_pkg - shared types and constants for the key debounce event queue
// Word formats, request codes and sizing of the counter and event stores.
// ----------------------------------------------------------------------------
`default_nettype none

package kdeq_pkg;

   // sizing
   localparam int NUM_KEYS     = 6;
   localparam int QUEUE_DEPTH  = 8;
   localparam int KEY_IDX_W    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
   localparam int Q_IDX_W      = $clog2(QUEUE_DEPTH);
   localparam int Q_CNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int Q_SUM_W      = Q_CNT_W + 1;

   // fixed field widths
   localparam int REQ_TYPE_W   = 2;
   localparam int LEVELS_W     = 6;
   localparam int KEY_CODE_W   = 6;
   localparam int PENDING_W    = 4;
   localparam int THRESH_W     = 7;
   localparam int RUN_W        = 8;

   localparam logic [THRESH_W-1:0]     THRESHOLD_RESET = 7'd100;
   localparam logic signed [RUN_W-1:0] RUN_MAX         = 8'sd127;
   localparam logic signed [RUN_W-1:0] RUN_MIN         = -8'sd127;

   // request codes
   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_SCAN  = 2'd0,
      REQ_POP   = 2'd1,
      REQ_CLEAR = 2'd2
   } req_code_type;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0] req_type;
      logic [LEVELS_W-1:0]   button_levels;
   } req_word_type;

   typedef struct packed {
      logic                  key_valid;
      logic [KEY_CODE_W-1:0] key_code;
      logic [KEY_CODE_W-1:0] held_keys;
      logic [PENDING_W-1:0]  pending_count;
   } rsp_word_type;

endpackage

`default_nettype wire

/* hw/rtl/key_debounce_event_queue.sv */
// ----------------------------------------------------------------------------
// key_debounce_event_queue - debounced button scanner with key event queue
// Per-button run counters and the event queue live in small synchronous
// memories; a two-stage read / update pipeline serves one word per cycle while rsp_ready allows.
// ----------------------------------------------------------------------------
`default_nettype none

// The block takes one request word per clock and returns exactly one response
// word per request. At accept a request issues the reads of the scanned
// button's run counter and of the queue head slot; in stage 1 it updates the
// counter, held mask and queue and loads the response register. Reads that
// hit an entry written in the same cycle are forwarded, so back-to-back
// requests run at full rate; the only stall comes from rsp_ready. Counter
// entries carry a valid bit that reset clears, so no clearing pass is needed
// after reset. The user must write the debounce threshold through csr_wr_en /
// csr_wr_data only while the block is idle; the block does not enforce this.
module key_debounce_event_queue
   import kdeq_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // request channel
   input  wire logic                 req_valid,
   output      logic                 req_ready,
   input  wire req_word_type         req_word,
   // response channel
   output      logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   output      rsp_word_type         rsp_word,
   // threshold register
   input  wire logic                 csr_wr_en,
   input  wire logic [THRESH_W-1:0]  csr_wr_data
);

   // ------------------------------------------------------------------------
   // declarations
   // ------------------------------------------------------------------------
   logic [THRESH_W-1:0]         thresh_ff;

   logic                        s1_valid_ff;
   req_code_type                s1_req_ff;
   logic [LEVELS_W-1:0]         s1_levels_ff;
   logic [KEY_IDX_W-1:0]        s1_idx_ff;

   logic [KEY_IDX_W-1:0]        scan_ff, scan_in;
   logic [NUM_KEYS-1:0]         held_ff, held_in;
   logic [Q_IDX_W-1:0]          head_ff, head_in;
   logic [Q_CNT_W-1:0]          count_ff, count_in;

   // run counter memory with per-entry valid bits
   logic signed [RUN_W-1:0]     cnt_mem [NUM_KEYS];
   logic [NUM_KEYS-1:0]         cnt_vld_ff;
   logic signed [RUN_W-1:0]     cnt_rd_ff;

   // event queue memory
   logic [KEY_CODE_W-1:0]       q_mem [QUEUE_DEPTH];
   logic [KEY_CODE_W-1:0]       q_rd_ff;

   logic                        rsp_valid_ff;
   rsp_word_type                rsp_word_ff, rsp_word_in;

   logic                        req_acc;
   logic                        s1_adv;
   req_code_type                acc_req;

   logic signed [RUN_W-1:0]     lim_s;
   logic signed [RUN_W-1:0]     cnt_c0, cnt_c1, cnt_new;
   logic                        pressed;
   logic                        confirm_press, confirm_release;
   logic [NUM_KEYS-1:0]         key_bit;
   logic [KEY_CODE_W-1:0]       key_code6;
   logic                        cnt_we;
   logic                        q_we;
   logic [Q_SUM_W-1:0]          slot_sum;
   logic [Q_IDX_W-1:0]          q_waddr;
   logic                        pop_hit;

   // ------------------------------------------------------------------------
   // handshake
   // ------------------------------------------------------------------------
   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign req_acc   = req_valid && req_ready;
   assign acc_req   = req_code_type'(req_word.req_type);

   // ------------------------------------------------------------------------
   // threshold register
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESHOLD_RESET;
      end else if (csr_wr_en) begin
         thresh_ff <= csr_wr_data;
      end
   end

   // ------------------------------------------------------------------------
   // scan index advances when a scan request is accepted, it depends on the request alone
   // ------------------------------------------------------------------------
   always_comb begin
      scan_in = scan_ff;
      if (req_acc && (acc_req == REQ_SCAN)) begin
         scan_in = (scan_ff == KEY_IDX_W'(NUM_KEYS - 1)) ? '0 : scan_ff + 1'b1;
      end
   end

   // ------------------------------------------------------------------------
   // stage 1 register
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         scan_ff     <= '0;
      end else begin
         scan_ff <= scan_in;
         if (req_acc) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_req_ff    <= acc_req;
         s1_levels_ff <= req_word.button_levels;
         s1_idx_ff    <= scan_ff;
      end
   end

   // ------------------------------------------------------------------------
   // counter update (stage 1)
   // ------------------------------------------------------------------------
   always_comb begin
      lim_s           = $signed({1'b0, thresh_ff});
      pressed         = !s1_levels_ff[s1_idx_ff];
      confirm_press   = 1'b0;
      confirm_release = 1'b0;
      if (pressed) begin
         cnt_c0 = (cnt_rd_ff < 0) ? '0 : cnt_rd_ff;
         cnt_c1 = (cnt_c0 < RUN_MAX) ? cnt_c0 + 8'sd1 : cnt_c0;
         cnt_new = cnt_c1;
         if (cnt_c1 > lim_s) begin
            cnt_new       = lim_s;
            confirm_press = 1'b1;
         end
      end else begin
         cnt_c0 = (cnt_rd_ff > 0) ? '0 : cnt_rd_ff;
         cnt_c1 = (cnt_c0 > RUN_MIN) ? cnt_c0 - 8'sd1 : cnt_c0;
         cnt_new = cnt_c1;
         if (cnt_c1 < -lim_s) begin
            cnt_new         = -lim_s;
            confirm_release = 1'b1;
         end
      end
   end

   // one-hot of the scanned key, in mask and code widths
   always_comb begin
      for (int b = 0; b < NUM_KEYS; b++) begin
         key_bit[b] = (s1_idx_ff == KEY_IDX_W'(b));
      end
      for (int b = 0; b < KEY_CODE_W; b++) begin
         key_code6[b] = (b < NUM_KEYS) && (s1_idx_ff == KEY_IDX_W'(b));
      end
   end

   // ------------------------------------------------------------------------
   // held mask, queue pointers and response (stage 1)
   // ------------------------------------------------------------------------
   always_comb begin
      held_in  = held_ff;
      head_in  = head_ff;
      count_in = count_ff;
      cnt_we   = 1'b0;
      q_we     = 1'b0;
      pop_hit  = 1'b0;
      slot_sum = Q_SUM_W'(head_ff) + Q_SUM_W'(count_ff);
      q_waddr  = (slot_sum >= Q_SUM_W'(QUEUE_DEPTH))
                 ? Q_IDX_W'(slot_sum - Q_SUM_W'(QUEUE_DEPTH))
                 : Q_IDX_W'(slot_sum);
      if (s1_adv) begin
         unique case (s1_req_ff)
            REQ_SCAN: begin
               cnt_we = 1'b1;
               if (confirm_press && ((held_ff & key_bit) == '0)) begin
                  held_in = held_ff | key_bit;
                  if (count_ff < Q_CNT_W'(QUEUE_DEPTH)) begin
                     q_we     = 1'b1;
                     count_in = count_ff + 1'b1;
                  end
               end
               if (confirm_release) begin
                  held_in = held_ff & ~key_bit;
               end
            end
            REQ_POP: begin
               if (count_ff != '0) begin
                  pop_hit  = 1'b1;
                  head_in  = (head_ff == Q_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
                  count_in = count_ff - 1'b1;
               end
            end
            REQ_CLEAR: begin
               count_in = '0;
            end
            default: begin
            end
         endcase
      end

      rsp_word_in.key_valid     = pop_hit;
      rsp_word_in.key_code      = pop_hit ? q_rd_ff : '0;
      for (int b = 0; b < KEY_CODE_W; b++) begin
         rsp_word_in.held_keys[b] = (b < NUM_KEYS) ? held_in[b % NUM_KEYS] : 1'b0;
      end
      rsp_word_in.pending_count = PENDING_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= '0;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         held_ff  <= held_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // ------------------------------------------------------------------------
   // run counter memory: read at accept, write from stage 1, forward on hit
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[s1_idx_ff] <= cnt_new;
      end
      if (req_acc) begin
         if (cnt_we && (s1_idx_ff == scan_ff)) begin
            cnt_rd_ff <= cnt_new;
         end else if (cnt_vld_ff[scan_ff]) begin
            cnt_rd_ff <= cnt_mem[scan_ff];
         end else begin
            cnt_rd_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_vld_ff <= '0;
      end else if (cnt_we) begin
         cnt_vld_ff <= cnt_vld_ff | key_bit;
      end
   end

   // ------------------------------------------------------------------------
   // event queue memory: head read at accept, push from stage 1
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (q_we) begin
         q_mem[q_waddr] <= key_code6;
      end
      if (req_acc) begin
         if (q_we && (q_waddr == head_in)) begin
            q_rd_ff <= key_code6;
         end else begin
            q_rd_ff <= q_mem[head_in];
         end
      end
   end

   // ------------------------------------------------------------------------
   // response register
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
`ifndef SYNTHESIS
   // queue never holds more events than slots
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= Q_CNT_W'(QUEUE_DEPTH))
      else $error("event count above queue depth");

   // a popped event is a one-hot key code
   a_pop_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.key_valid |-> $onehot(rsp_word_ff.key_code))
      else $error("popped key code not one-hot");

   // an accepted word always occupies stage 1 next cycle
   a_accept_fill: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> s1_valid_ff)
      else $error("accepted word lost before stage 1");

   // a stage 1 word that cannot advance keeps the stage occupied
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |=> s1_valid_ff && $stable(s1_idx_ff))
      else $error("stalled stage 1 word dropped");

   // a push only happens with room in the queue
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      q_we |-> count_ff < Q_CNT_W'(QUEUE_DEPTH))
      else $error("push into a full queue");
`endif

endmodule

`default_nettype wire
